/* rtl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// Types, codes and constants shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int Width = 32;
	localparam logic [63:0] Lim = 64'(1) << (Width - 1);

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL   = 3'd2,
		OP_DIV   = 3'd3,
		OP_LESS  = 3'd4,
		OP_EQUAL = 3'd5,
		OP_NEG   = 3'd6,
		OP_MAKE  = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIV0 = 2'd2,
		ST_ZDEN = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_GCD,
		BK_DIV,
		BK_FIN
	} back_state_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic [30:0]        b_den;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic               compare_true;
		logic [1:0]         status;
	} out_item_t;

	// work handed from front to back
	typedef struct packed {
		logic        bypass;
		logic        neg;
		logic [63:0] mag;
		logic [63:0] den;
		logic        cmp;
		status_t     status;
	} job_t;

endpackage

/* rtl/rau_front.sv */
// ----------------------------------------------------------------------------
// rau_front
// Accepts items, standardizes operand a, forms cross products and classifies.
// ----------------------------------------------------------------------------
module rau_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  rau_pkg::in_item_t item,
	output logic             job_valid,
	input  logic             job_full,
	output rau_pkg::job_t    job
);

	logic                  v_s1, v_s2;
	logic signed [32:0]    an_s1, ad_s1, bn_s1, bd_s1;
	rau_pkg::action_t      op_s1, op_s2;
	logic                  zden_s1, zden_s2;
	logic signed [65:0]    px_s2, py_s2, pz_s2;
	logic signed [32:0]    an_s2, ad_s2;

	logic                  acc, move2;
	logic signed [32:0]    an_d, ad_d, bn_d, bd_d, m2;
	rau_pkg::action_t      op_d;
	logic signed [65:0]    n, d;

	assign move2 = !v_s2 || !job_full;
	assign full  = v_s1 && !move2;
	assign acc   = push && !full;

	always_comb begin
		op_d = rau_pkg::action_t'(item.action);
		an_d = {{(33 - rau_pkg::Width){item.a_num[rau_pkg::Width-1]}},
			item.a_num[rau_pkg::Width-1:0]};
		ad_d = {{(33 - rau_pkg::Width){item.a_den[rau_pkg::Width-1]}},
			item.a_den[rau_pkg::Width-1:0]};
		bn_d = {{(33 - rau_pkg::Width){item.b_num[rau_pkg::Width-1]}},
			item.b_num[rau_pkg::Width-1:0]};
		bd_d = {{(34 - rau_pkg::Width){1'b0}}, item.b_den[rau_pkg::Width-2:0]};
		if (ad_d < 0) begin
			an_d = -an_d;
			ad_d = -ad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (acc)
				v_s1 <= 1'b1;
			else if (move2)
				v_s1 <= 1'b0;
			if (move2)
				v_s2 <= v_s1;
		end
	end

	assign m2 = (op_s1 == rau_pkg::OP_MUL) ? bn_s1 : bd_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			an_s1   <= an_d;
			ad_s1   <= ad_d;
			bn_s1   <= bn_d;
			bd_s1   <= bd_d;
			op_s1   <= op_d;
			zden_s1 <= (ad_d == 0) || (op_d <= rau_pkg::OP_EQUAL && bd_d == 0);
		end
		if (move2) begin
			px_s2   <= an_s1 * m2;
			py_s2   <= bn_s1 * ad_s1;
			pz_s2   <= ad_s1 * bd_s1;
			an_s2   <= an_s1;
			ad_s2   <= ad_s1;
			op_s2   <= op_s1;
			zden_s2 <= zden_s1;
		end
	end

	always_comb begin
		n          = px_s2;
		d          = pz_s2;
		job.bypass = 1'b0;
		job.cmp    = 1'b0;
		job.status = rau_pkg::ST_OK;
		case (op_s2)
			rau_pkg::OP_ADD: n = px_s2 + py_s2;
			rau_pkg::OP_SUB: n = px_s2 - py_s2;
			rau_pkg::OP_MUL: n = px_s2;
			rau_pkg::OP_DIV: begin
				if (py_s2 < 0) begin
					n = -px_s2;
					d = -py_s2;
				end else begin
					d = py_s2;
				end
				if (py_s2 == 0) begin
					job.bypass = 1'b1;
					job.status = rau_pkg::ST_DIV0;
				end
			end
			rau_pkg::OP_LESS: begin
				job.bypass = 1'b1;
				job.cmp    = px_s2 < py_s2;
			end
			rau_pkg::OP_EQUAL: begin
				job.bypass = 1'b1;
				job.cmp    = px_s2 == py_s2;
			end
			rau_pkg::OP_NEG: begin
				n = -66'(an_s2);
				d = 66'(ad_s2);
			end
			rau_pkg::OP_MAKE: begin
				n = 66'(an_s2);
				d = 66'(ad_s2);
			end
			default: n = px_s2;
		endcase
		if (zden_s2) begin
			job.bypass = 1'b1;
			job.cmp    = 1'b0;
			job.status = rau_pkg::ST_ZDEN;
		end
		job.neg = n < 0;
		job.mag = n < 0 ? 64'(-n) : 64'(n);
		job.den = 64'(d);
	end

	assign job_valid = v_s2;

endmodule

/* rtl/rau_queue.sv */
// ----------------------------------------------------------------------------
// rau_queue
// Four-entry queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module rau_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          full,
	input  rau_pkg::job_t wr_job,
	input  logic          rd,
	output logic          empty,
	output rau_pkg::job_t rd_job
);

	rau_pkg::job_t mem_q [4];
	logic [1:0]    wp_q, rp_q;
	logic [2:0]    cnt_q;
	logic          wr, rd_ok;

	assign full  = cnt_q == 3'd4;
	assign empty = cnt_q == 3'd0;
	assign wr    = wr_valid && !full;
	assign rd_ok = rd && !empty;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 2'd1;
			if (rd_ok)
				rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_job;
	end

endmodule

/* rtl/rau_back.sv */
// ----------------------------------------------------------------------------
// rau_back
// Binary gcd, two exact divisions by the gcd, range check and result register.
// ----------------------------------------------------------------------------
module rau_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_empty,
	input  rau_pkg::job_t      job,
	output logic               job_pop,
	output logic               empty,
	input  logic               pop,
	output rau_pkg::out_item_t result
);

	rau_pkg::back_state_t state_q, state_d;
	rau_pkg::job_t        job_q;
	logic [63:0]          x_q, y_q, g_q, n_q, d_q, rn_q, rd_q;
	logic [6:0]           k_q;
	logic [5:0]           cnt_q;
	logic                 out_v_q;
	rau_pkg::out_item_t   out_q, fin;
	logic                 load_job, load_out;
	logic [64:0]          tn, td;
	logic                 qn, qd;
	logic [63:0]          negn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rau_pkg::BK_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		load_job = 1'b0;
		load_out = 1'b0;
		case (state_q)
			rau_pkg::BK_IDLE: begin
				if (!job_empty) begin
					job_pop  = 1'b1;
					load_job = 1'b1;
					state_d  = job.bypass ? rau_pkg::BK_FIN : rau_pkg::BK_GCD;
				end
			end
			rau_pkg::BK_GCD: begin
				if (x_q == 64'd0)
					state_d = rau_pkg::BK_DIV;
			end
			rau_pkg::BK_DIV: begin
				if (cnt_q == 6'd63)
					state_d = rau_pkg::BK_FIN;
			end
			rau_pkg::BK_FIN: begin
				if (!out_v_q || pop) begin
					load_out = 1'b1;
					state_d  = rau_pkg::BK_IDLE;
				end
			end
			default: state_d = rau_pkg::BK_IDLE;
		endcase
	end

	assign tn = {rn_q, n_q[63]};
	assign td = {rd_q, d_q[63]};
	assign qn = tn >= {1'b0, g_q};
	assign qd = td >= {1'b0, g_q};

	always_ff @(posedge clk) begin
		if (load_job) begin
			job_q <= job;
			x_q   <= job.mag;
			y_q   <= job.den;
			k_q   <= '0;
			n_q   <= job.mag;
			d_q   <= job.den;
		end
		case (state_q)
			rau_pkg::BK_GCD: begin
				if (x_q == 64'd0) begin
					g_q   <= y_q << k_q[5:0];
					rn_q  <= '0;
					rd_q  <= '0;
					cnt_q <= '0;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 7'd1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q >= y_q) begin
					x_q <= (x_q - y_q) >> 1;
				end else begin
					y_q <= (y_q - x_q) >> 1;
				end
			end
			rau_pkg::BK_DIV: begin
				rn_q  <= qn ? 64'(tn - {1'b0, g_q}) : tn[63:0];
				rd_q  <= qd ? 64'(td - {1'b0, g_q}) : td[63:0];
				n_q   <= {n_q[62:0], qn};
				d_q   <= {d_q[62:0], qd};
				cnt_q <= cnt_q + 6'd1;
			end
			default: ;
		endcase
	end

	assign negn = -n_q;

	always_comb begin
		fin.res_num      = '0;
		fin.res_den      = 31'd1;
		fin.compare_true = 1'b0;
		fin.status       = job_q.status;
		if (job_q.bypass) begin
			if (job_q.status == rau_pkg::ST_OK)
				fin.compare_true = job_q.cmp;
		end else if (d_q > rau_pkg::Lim - 64'd1 ||
			(job_q.neg ? n_q > rau_pkg::Lim : n_q > rau_pkg::Lim - 64'd1)) begin
			fin.status = rau_pkg::ST_OVF;
		end else begin
			fin.res_num = job_q.neg ? negn[31:0] : n_q[31:0];
			fin.res_den = d_q[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (load_out)
			out_v_q <= 1'b1;
		else if (pop)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= fin;
	end

	assign empty  = !out_v_q;
	assign result = out_q;

`ifndef ASSERT_OFF
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.status != rau_pkg::ST_OK |->
		out_q.res_num == '0 && out_q.res_den == 31'd1 && !out_q.compare_true)
		else $error("error result not cleared");
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> out_q.res_den != '0)
		else $error("zero result denominator");
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rau_pkg::BK_DIV |-> g_q != '0)
		else $error("zero gcd in division");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !pop |=> out_v_q && $stable(out_q))
		else $error("result changed while waiting");
`endif

endmodule

/* rtl/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Rational add, subtract, multiply, divide, compare, negate and make, with
// results reduced by their gcd.
// ----------------------------------------------------------------------------
// Items enter through a two-stage front that forms the cross products, wait
// in a four-entry queue, and are reduced one at a time by the back. A compare,
// a divide by zero or a zero-denominator result skips the gcd and divisions;
// an arithmetic result takes the binary gcd (one shift or subtract per cycle
// on the 64-bit cross products) and then the two parallel restoring divisions
// by the gcd, which form 64-bit quotients. The back's gcd loop and divisions
// set the sustained rate.
module rational_arithmetic_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  rau_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output rau_pkg::out_item_t result
);

	rau_pkg::job_t f_job, q_job;
	logic          f_valid, q_full, q_empty, q_pop;

	rau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.job_valid(f_valid),
		.job_full (q_full),
		.job      (f_job)
	);

	rau_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.full    (q_full),
		.wr_job  (f_job),
		.rd      (q_pop),
		.empty   (q_empty),
		.rd_job  (q_job)
	);

	rau_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(q_empty),
		.job      (q_job),
		.job_pop  (q_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

/* sim/tb_rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// Drives directed and random rational operations through the queue ports and
// checks every result against an exact predictor of the reduced fraction.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumRandom = 800;
	localparam longint CycleLimit = 1000000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	rau_pkg::in_item_t item;
	logic empty;
	logic pop;
	rau_pkg::out_item_t result;

	rau_pkg::out_item_t pending_q[$];
	int errors;
	longint cycles;
	int n_ops[8];
	int n_status[4];
	bit sender_done;
	bit calm;

	rational_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	typedef struct {
		rau_pkg::action_t   op;
		logic [31:0]        an;
		logic [31:0]        ad;
		logic [31:0]        bn;
		logic [30:0]        bd;
		bit                 known;
		rau_pkg::out_item_t res;
	} vector_t;

	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic rau_pkg::status_t reduce(longint n, logic [63:0] d,
		output rau_pkg::out_item_t r);
		bit neg;
		logic [63:0] mag;
		logic [63:0] g;
		neg = n < 0;
		mag = neg ? 64'(-n) : 64'(n);
		g = gcd64(mag, d);
		mag = mag / g;
		d = d / g;
		r = '0;
		r.res_den = 31'd1;
		if (d > rau_pkg::Lim - 1) return rau_pkg::ST_OVF;
		if (neg ? (mag > rau_pkg::Lim) : (mag > rau_pkg::Lim - 1)) return rau_pkg::ST_OVF;
		r.res_num = neg ? 32'(-longint'(mag)) : 32'(mag);
		r.res_den = 31'(d);
		return rau_pkg::ST_OK;
	endfunction

	function automatic rau_pkg::out_item_t rational_result(rau_pkg::in_item_t x);
		longint an, ad, bn, bd, nn, dd;
		rau_pkg::out_item_t r;
		rau_pkg::status_t st;
		r = '0;
		r.res_den = 31'd1;
		st = rau_pkg::ST_OK;
		an = longint'(signed'(x.a_num));
		ad = longint'(signed'(x.a_den));
		bn = longint'(signed'(x.b_num));
		bd = longint'({1'b0, x.b_den});
		if (ad == 0 || (x.action <= rau_pkg::OP_EQUAL && bd == 0)) begin
			st = rau_pkg::ST_ZDEN;
		end else begin
			if (ad < 0) begin
				an = -an;
				ad = -ad;
			end
			case (rau_pkg::action_t'(x.action))
				rau_pkg::OP_ADD: st = reduce(an * bd + bn * ad, 64'(ad * bd), r);
				rau_pkg::OP_SUB: st = reduce(an * bd - bn * ad, 64'(ad * bd), r);
				rau_pkg::OP_MUL: st = reduce(an * bn, 64'(ad * bd), r);
				rau_pkg::OP_DIV: begin
					if (bn == 0) begin
						st = rau_pkg::ST_DIV0;
					end else begin
						nn = an * bd;
						dd = ad * bn;
						if (dd < 0) begin
							dd = -dd;
							nn = -nn;
						end
						st = reduce(nn, 64'(dd), r);
					end
				end
				rau_pkg::OP_LESS: r.compare_true = an * bd < bn * ad;
				rau_pkg::OP_EQUAL: r.compare_true = an * bd == bn * ad;
				rau_pkg::OP_NEG: st = reduce(-an, 64'(ad), r);
				default: st = reduce(an, 64'(ad), r);
			endcase
		end
		if (st != rau_pkg::ST_OK) begin
			r = '0;
			r.res_den = 31'd1;
		end
		r.status = st;
		return r;
	endfunction

	task automatic report(string what, rau_pkg::out_item_t got, rau_pkg::out_item_t want);
		errors++;
		$display("error %s: got %0d/%0d cmp %0b st %0d, want %0d/%0d cmp %0b st %0d",
			what, signed'(got.res_num), got.res_den, got.compare_true, got.status,
			signed'(want.res_num), want.res_den, want.compare_true, want.status);
	endtask

	function automatic bit idle_now();
		return !calm && $urandom_range(99) < 15;
	endfunction

	task automatic send(rau_pkg::in_item_t x, bit known, rau_pkg::out_item_t res);
		rau_pkg::out_item_t p;
		while (idle_now()) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= x;
		do @(posedge clk); while (full);
		p = rational_result(x);
		if (known && p != res) report("directed row", p, res);
		pending_q.push_back(known ? res : p);
		n_ops[x.action]++;
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(5))
			0: return 32'(int'($urandom_range(20)) - 10);
			1: return 32'h8000_0000 + 32'($urandom_range(2));
			2: return 32'h7fff_ffff - 32'($urandom_range(2));
			3: return 32'($urandom_range(65535)) * 32'($urandom_range(7) + 1);
			default: return $urandom();
		endcase
	endfunction

	function automatic rau_pkg::out_item_t frac(int n, int d, logic c, rau_pkg::status_t s);
		rau_pkg::out_item_t r;
		r.res_num = n;
		r.res_den = 31'(d);
		r.compare_true = c;
		r.status = s;
		return r;
	endfunction

	// result side
	initial begin
		rau_pkg::out_item_t want;
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (pending_q.size() == 0) begin
					report("unexpected", result, result);
				end else begin
					want = pending_q.pop_front();
					n_status[result.status]++;
					if (result != want) report("mismatch", result, want);
				end
			end
			pop <= !idle_now();
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("timeout with %0d results pending", pending_q.size());
				$display("rational_arithmetic_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		vector_t dir[$];
		rau_pkg::in_item_t x;
		int k;
		errors = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		dir = '{
			'{rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 31'd3, 1,
				frac(5, 6, 0, rau_pkg::ST_OK)},
			'{rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 31'd2, 1,
				frac(0, 1, 0, rau_pkg::ST_OK)},
			'{rau_pkg::OP_MUL, 32'd2, 32'd3, 32'd3, 31'd4, 1,
				frac(1, 2, 0, rau_pkg::ST_OK)},
			'{rau_pkg::OP_DIV, 32'd1, 32'd2, 32'd0, 31'd1, 1,
				frac(0, 1, 0, rau_pkg::ST_DIV0)},
			'{rau_pkg::OP_DIV, 32'd1, 32'd2, -32'sd1, 31'd4, 1,
				frac(-2, 1, 0, rau_pkg::ST_OK)},
			'{rau_pkg::OP_LESS, 32'd1, 32'd3, 32'd1, 31'd2, 1,
				frac(0, 1, 1, rau_pkg::ST_OK)},
			'{rau_pkg::OP_EQUAL, 32'd2, 32'd4, 32'd1, 31'd2, 1,
				frac(0, 1, 1, rau_pkg::ST_OK)},
			'{rau_pkg::OP_EQUAL, 32'd1, 32'd0, 32'd1, 31'd2, 1,
				frac(0, 1, 0, rau_pkg::ST_ZDEN)},
			'{rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 31'd0, 1,
				frac(0, 1, 0, rau_pkg::ST_ZDEN)},
			'{rau_pkg::OP_NEG, 32'h8000_0000, 32'd1, 32'd0, 31'd0, 1,
				frac(0, 1, 0, rau_pkg::ST_OVF)},
			'{rau_pkg::OP_NEG, 32'd3, -32'sd6, 32'd0, 31'd0, 1,
				frac(1, 2, 0, rau_pkg::ST_OK)},
			'{rau_pkg::OP_MAKE, 32'd4, -32'sd8, 32'd0, 31'd0, 1,
				frac(-1, 2, 0, rau_pkg::ST_OK)},
			'{rau_pkg::OP_MAKE, 32'd4, 32'd0, 32'd0, 31'd5, 1,
				frac(0, 1, 0, rau_pkg::ST_ZDEN)},
			'{rau_pkg::OP_MAKE, 32'h8000_0000, -32'sd1, 32'd0, 31'd0, 1,
				frac(0, 1, 0, rau_pkg::ST_OVF)},
			'{rau_pkg::OP_MAKE, 32'd1, 32'h8000_0000, 32'd0, 31'd0, 1,
				frac(0, 1, 0, rau_pkg::ST_OVF)},
			'{rau_pkg::OP_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 31'd1, 1,
				frac(0, 1, 0, rau_pkg::ST_OVF)},
			'{rau_pkg::OP_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 31'd1, 1,
				frac(0, 1, 0, rau_pkg::ST_OVF)},
			'{rau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
				31'h7fff_ffff, 0, '0},
			'{rau_pkg::OP_LESS, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
				31'h7fff_ffff, 0, '0},
			'{rau_pkg::OP_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000,
				31'h5555_5555, 0, '0},
			'{rau_pkg::OP_EQUAL, 32'd6, 32'd9, 32'd4, 31'd6, 0, '0},
			'{rau_pkg::OP_MUL, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 31'h2aaa_aaaa, 0, '0}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir[i]) begin
			x.action = dir[i].op;
			x.a_num = dir[i].an;
			x.a_den = dir[i].ad;
			x.b_num = dir[i].bn;
			x.b_den = dir[i].bd;
			send(x, dir[i].known, dir[i].res);
		end
		for (k = 0; k < NumRandom; k++) begin
			calm = (k >= 300 && k < 400);
			if (k == 500) begin
				push <= 1'b0;
				wait (pending_q.size() == 0);
			end
			x.action = 3'($urandom_range(7));
			x.a_num = rand_val();
			x.a_den = ($urandom_range(19) == 0) ? 32'd0 : rand_val();
			x.b_num = ($urandom_range(9) == 0) ? 32'd0 : rand_val();
			x.b_den = ($urandom_range(19) == 0) ? 31'd0 : 31'(rand_val());
			send(x, 0, '0);
		end
		push <= 1'b0;
		calm = 1'b0;
		wait (pending_q.size() == 0);
		repeat (300) @(posedge clk);
		$display("ops add %0d sub %0d mul %0d div %0d less %0d eq %0d neg %0d make %0d",
			n_ops[0], n_ops[1], n_ops[2], n_ops[3], n_ops[4], n_ops[5], n_ops[6], n_ops[7]);
		$display("status ok %0d overflow %0d div-by-zero %0d zero-den %0d, errors %0d",
			n_status[0], n_status[1], n_status[2], n_status[3], errors);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("rational_arithmetic_unit: match");
		end else begin
			$display("rational_arithmetic_unit: mismatch");
		end
		$finish;
	end

endmodule
